// ----- design/limit_order_book_matcher_unit_assert.svh -----
// ----------------------------------------------------------------------------
// limit order book matcher assertion macros
// concurrent check wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define LOBM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lobm assertion failed");
`define LOBM_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("lobm assertion failed");
`else
`define LOBM_ASSERT(label, clk, rst, prop)
`define LOBM_ASSERT_NORST(label, clk, prop)
`endif

`endif

// ----- design/lobm_pkg.sv -----
// ----------------------------------------------------------------------------
// lobm_pkg
// shared types and codes of the limit order book matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lobm_pkg;

   localparam int ID_W    = 32;
   localparam int PRICE_W = 20;
   localparam int QTY_W   = 24;
   localparam int ARR_W   = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   localparam logic KIND_TRADE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_CANCEL  = 2'd1,
      OP_MODIFY  = 2'd2,
      OP_END_DAY = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      OT_GTC    = 3'd0,
      OT_FAK    = 3'd1,
      OT_FOK    = 3'd2,
      OT_GFD    = 3'd3,
      OT_MARKET = 3'd4
   } order_kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_DUPLICATE   = 3'd1,
      ST_NO_CROSS    = 3'd2,
      ST_CANNOT_FILL = 3'd3,
      ST_EMPTY_SIDE  = 3'd4,
      ST_UNKNOWN_ID  = 3'd5,
      ST_BOOK_FULL   = 3'd6,
      ST_CANCELLED   = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_SCAN_END,
      ENG_DECIDE,
      ENG_CHECK,
      ENG_TRADE_BID,
      ENG_TRADE_ASK,
      ENG_STATUS
   } eng_state_type;

   typedef struct packed {
      op_type               op;
      logic [ID_W-1:0]      order_id;
      logic                 side;
      order_kind_type       otype;
      logic [PRICE_W-1:0]   price;
      logic [QTY_W-1:0]     quantity;
   } cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]      order_id;
      logic                 side;
      logic [PRICE_W-1:0]   price;
      logic [QTY_W-1:0]     remaining;
      logic [ARR_W-1:0]     arrival;
   } slot_type;

   typedef struct packed {
      logic                 kind;
      status_type           status;
      logic [ID_W-1:0]      bid_id;
      logic [ID_W-1:0]      ask_id;
      logic [PRICE_W-1:0]   bid_price;
      logic [PRICE_W-1:0]   ask_price;
      logic [QTY_W-1:0]     trade_quantity;
      logic                 last;
   } rsp_type;

endpackage

// ----- design/lobm_front.sv -----
// ----------------------------------------------------------------------------
// lobm_front
// accepts requests, normalizes the order type and queues commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lobm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [79:0]         req_tdata,
   input  logic [1:0]          req_tuser,
   output logic                cmd_valid,
   output lobm_pkg::cmd_type   cmd,
   input  logic                cmd_pop
);

   lobm_pkg::cmd_type          queue_ff [lobm_pkg::QUEUE_DEPTH];
   logic [lobm_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [lobm_pkg::QCNT_W-1:0] count_ff;
   lobm_pkg::cmd_type          cmd_in;
   logic                       push;

   always_comb begin
      cmd_in.op       = lobm_pkg::op_type'(req_tuser);
      cmd_in.order_id = req_tdata[31:0];
      cmd_in.side     = req_tdata[32];
      case (lobm_pkg::order_kind_type'(req_tdata[35:33]))
         lobm_pkg::OT_FAK:    cmd_in.otype = lobm_pkg::OT_FAK;
         lobm_pkg::OT_FOK:    cmd_in.otype = lobm_pkg::OT_FOK;
         lobm_pkg::OT_GFD:    cmd_in.otype = lobm_pkg::OT_GFD;
         lobm_pkg::OT_MARKET: cmd_in.otype = lobm_pkg::OT_MARKET;
         default:             cmd_in.otype = lobm_pkg::OT_GTC;
      endcase
      cmd_in.price    = req_tdata[55:36];
      cmd_in.quantity = req_tdata[79:56];
   end

   assign req_tready = count_ff != lobm_pkg::QCNT_W'(lobm_pkg::QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = count_ff != '0;
   assign cmd        = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, cmd_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ----- design/lobm_engine.sv -----
// ----------------------------------------------------------------------------
// lobm_engine
// book store and sequencer: slot scans, checks, fills and status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lobm_engine #(
   parameter int ORDER_SLOTS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  lobm_pkg::cmd_type   cmd,
   output logic                cmd_pop,
   input  logic                out_free,
   output logic                emit_valid,
   output lobm_pkg::rsp_type   emit_item
);

   localparam int SW    = $clog2(ORDER_SLOTS);
   localparam int SUM_W = lobm_pkg::QTY_W + SW;
   localparam logic [SW-1:0] LAST_IDX = SW'(ORDER_SLOTS - 1);

   lobm_pkg::eng_state_type state_ff, state_in;
   lobm_pkg::cmd_type       cmd_ff, cmd_in;
   logic                    match_ff, match_in;
   lobm_pkg::status_type    status_ff, status_in;
   logic [lobm_pkg::ARR_W-1:0] counter_ff, counter_in;
   logic [SW-1:0]           new_idx_ff, new_idx_in;
   logic [lobm_pkg::QTY_W-1:0] q_ff, q_in;
   logic [ORDER_SLOTS-1:0]  valid_ff, valid_in;
   logic [ORDER_SLOTS-1:0]  day_ff;

   lobm_pkg::slot_type      mem [ORDER_SLOTS];
   logic                    mem_we;
   logic [SW-1:0]           mem_waddr;
   lobm_pkg::slot_type      mem_wdata;
   logic                    day_we;

   logic [SW-1:0]           addr_ff;
   logic                    rd_vld_ff;
   logic [SW-1:0]           rd_idx_ff;
   lobm_pkg::slot_type      rd_data_ff;
   logic                    scan_start;

   logic                    best_ok_ff [2];
   logic [SW-1:0]           best_idx_ff [2];
   lobm_pkg::slot_type      best_ff [2];
   logic [lobm_pkg::ARR_W-1:0] best_age_ff [2];
   logic [lobm_pkg::PRICE_W-1:0] worst_ff [2];
   logic [SUM_W-1:0]        fok_sum_ff;
   logic                    found_ok_ff, free_ok_ff;
   logic [SW-1:0]           found_idx_ff, free_idx_ff;

   logic [lobm_pkg::ARR_W-1:0] age_e;
   logic                    ent_valid;
   logic                    upd_best [2];
   logic                    upd_worst [2];
   logic                    in_limit;

   logic                    opp_ok;
   logic [lobm_pkg::PRICE_W-1:0] opp_best_price, opp_worst_price;
   logic                    fak_miss;
   logic [lobm_pkg::QTY_W-1:0] trade_q, bid_left, ask_left;

   // per-entry scan evaluation
   always_comb begin
      ent_valid = rd_vld_ff && valid_ff[rd_idx_ff];
      age_e     = counter_ff - rd_data_ff.arrival;
      for (int s = 0; s < 2; s++) begin
         upd_best[s]  = 1'b0;
         upd_worst[s] = 1'b0;
         if (ent_valid && rd_data_ff.side == 1'(s)) begin
            if (!best_ok_ff[s]) begin
               upd_best[s]  = 1'b1;
               upd_worst[s] = 1'b1;
            end else begin
               if (rd_data_ff.price != best_ff[s].price) begin
                  upd_best[s] = (s == 0) ? rd_data_ff.price > best_ff[s].price
                                         : rd_data_ff.price < best_ff[s].price;
               end else begin
                  upd_best[s] = age_e > best_age_ff[s];
               end
               upd_worst[s] = (s == 0) ? rd_data_ff.price < worst_ff[s]
                                       : rd_data_ff.price > worst_ff[s];
            end
         end
      end
      in_limit = (cmd_ff.side == lobm_pkg::SIDE_BUY) ? rd_data_ff.price <= cmd_ff.price
                                                     : rd_data_ff.price >= cmd_ff.price;
   end

   always_ff @(posedge clock) begin
      if (scan_start) begin
         for (int s = 0; s < 2; s++) begin
            best_ok_ff[s] <= 1'b0;
         end
         fok_sum_ff  <= '0;
         found_ok_ff <= 1'b0;
         free_ok_ff  <= 1'b0;
      end else if (rd_vld_ff) begin
         for (int s = 0; s < 2; s++) begin
            if (upd_best[s]) begin
               best_ok_ff[s]  <= 1'b1;
               best_idx_ff[s] <= rd_idx_ff;
               best_ff[s]     <= rd_data_ff;
               best_age_ff[s] <= age_e;
            end
            if (upd_worst[s]) begin
               worst_ff[s] <= rd_data_ff.price;
            end
         end
         if (ent_valid && rd_data_ff.side != cmd_ff.side && in_limit) begin
            fok_sum_ff <= fok_sum_ff + SUM_W'(rd_data_ff.remaining);
         end
         if (ent_valid && rd_data_ff.order_id == cmd_ff.order_id && !found_ok_ff) begin
            found_ok_ff  <= 1'b1;
            found_idx_ff <= rd_idx_ff;
         end
         if (!valid_ff[rd_idx_ff] && !free_ok_ff) begin
            free_ok_ff  <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
      end
   end

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff];
      rd_idx_ff  <= addr_ff;
      if (day_we) begin
         day_ff[mem_waddr] <= cmd_ff.otype == lobm_pkg::OT_GFD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         addr_ff   <= '0;
      end else begin
         rd_vld_ff <= state_ff == lobm_pkg::ENG_SCAN;
         if (scan_start) begin
            addr_ff <= '0;
         end else if (state_ff == lobm_pkg::ENG_SCAN && addr_ff != LAST_IDX) begin
            addr_ff <= addr_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (cmd_ff.side == lobm_pkg::SIDE_BUY) begin
         opp_ok          = best_ok_ff[1];
         opp_best_price  = best_ff[1].price;
         opp_worst_price = worst_ff[1];
      end else begin
         opp_ok          = best_ok_ff[0];
         opp_best_price  = best_ff[0].price;
         opp_worst_price = worst_ff[0];
      end
      fak_miss = !opp_ok || ((cmd_ff.side == lobm_pkg::SIDE_BUY)
                             ? cmd_ff.price < opp_best_price
                             : cmd_ff.price > opp_best_price);
      trade_q  = (best_ff[0].remaining < best_ff[1].remaining) ? best_ff[0].remaining
                                                               : best_ff[1].remaining;
      bid_left = best_ff[0].remaining - trade_q;
      ask_left = best_ff[1].remaining - q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lobm_pkg::ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      match_in   = match_ff;
      status_in  = status_ff;
      counter_in = counter_ff;
      new_idx_in = new_idx_ff;
      q_in       = q_ff;
      valid_in   = valid_ff;
      scan_start = 1'b0;
      cmd_pop    = 1'b0;
      mem_we     = 1'b0;
      day_we     = 1'b0;
      mem_waddr  = free_idx_ff;
      mem_wdata  = '{order_id: cmd_ff.order_id, side: cmd_ff.side,
                     price: (cmd_ff.otype == lobm_pkg::OT_MARKET) ? opp_worst_price
                                                                 : cmd_ff.price,
                     remaining: cmd_ff.quantity, arrival: counter_ff};
      emit_valid = 1'b0;
      emit_item  = '{kind: lobm_pkg::KIND_STATUS, status: status_ff, bid_id: '0,
                     ask_id: '0, bid_price: '0, ask_price: '0,
                     trade_quantity: '0, last: 1'b1};
      case (state_ff)
         lobm_pkg::ENG_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               cmd_in     = cmd;
               match_in   = 1'b0;
               scan_start = 1'b1;
               state_in   = lobm_pkg::ENG_SCAN;
            end
         end
         lobm_pkg::ENG_SCAN: begin
            if (addr_ff == LAST_IDX) begin
               state_in = lobm_pkg::ENG_SCAN_END;
            end
         end
         lobm_pkg::ENG_SCAN_END: begin
            state_in = match_ff ? lobm_pkg::ENG_CHECK : lobm_pkg::ENG_DECIDE;
         end
         lobm_pkg::ENG_DECIDE: begin
            state_in = lobm_pkg::ENG_STATUS;
            case (cmd_ff.op)
               lobm_pkg::OP_CANCEL: begin
                  if (found_ok_ff) begin
                     valid_in[found_idx_ff] = 1'b0;
                     status_in = lobm_pkg::ST_OK;
                  end else begin
                     status_in = lobm_pkg::ST_UNKNOWN_ID;
                  end
               end
               lobm_pkg::OP_MODIFY: begin
                  if (found_ok_ff) begin
                     valid_in[found_idx_ff] = 1'b0;
                     cmd_in.op    = lobm_pkg::OP_ADD;
                     cmd_in.otype = day_ff[found_idx_ff] ? lobm_pkg::OT_GFD
                                                          : lobm_pkg::OT_GTC;
                     scan_start   = 1'b1;
                     state_in     = lobm_pkg::ENG_SCAN;
                  end else begin
                     status_in = lobm_pkg::ST_UNKNOWN_ID;
                  end
               end
               lobm_pkg::OP_END_DAY: begin
                  valid_in  = valid_ff & ~day_ff;
                  status_in = lobm_pkg::ST_OK;
               end
               default: begin
                  if (found_ok_ff) begin
                     status_in = lobm_pkg::ST_DUPLICATE;
                  end else if (cmd_ff.quantity == '0) begin
                     status_in = lobm_pkg::ST_CANNOT_FILL;
                  end else if (cmd_ff.otype == lobm_pkg::OT_FAK && fak_miss) begin
                     status_in = lobm_pkg::ST_NO_CROSS;
                  end else if (cmd_ff.otype == lobm_pkg::OT_MARKET && !opp_ok) begin
                     status_in = lobm_pkg::ST_EMPTY_SIDE;
                  end else if (cmd_ff.otype == lobm_pkg::OT_FOK
                               && fok_sum_ff < SUM_W'(cmd_ff.quantity)) begin
                     status_in = lobm_pkg::ST_CANNOT_FILL;
                  end else if (!free_ok_ff) begin
                     status_in = lobm_pkg::ST_BOOK_FULL;
                  end else begin
                     mem_we     = 1'b1;
                     day_we     = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                     new_idx_in = free_idx_ff;
                     counter_in = counter_ff + 1'b1;
                     match_in   = 1'b1;
                     scan_start = 1'b1;
                     state_in   = lobm_pkg::ENG_SCAN;
                  end
               end
            endcase
         end
         lobm_pkg::ENG_CHECK: begin
            if (best_ok_ff[0] && best_ok_ff[1] && best_ff[0].price >= best_ff[1].price) begin
               state_in = lobm_pkg::ENG_TRADE_BID;
            end else begin
               state_in = lobm_pkg::ENG_STATUS;
               if (cmd_ff.otype == lobm_pkg::OT_FAK && valid_ff[new_idx_ff]) begin
                  valid_in[new_idx_ff] = 1'b0;
                  status_in = lobm_pkg::ST_CANCELLED;
               end else begin
                  status_in = lobm_pkg::ST_OK;
               end
            end
         end
         lobm_pkg::ENG_TRADE_BID: begin
            emit_valid = 1'b1;
            emit_item  = '{kind: lobm_pkg::KIND_TRADE, status: lobm_pkg::ST_OK,
                           bid_id: best_ff[0].order_id, ask_id: best_ff[1].order_id,
                           bid_price: best_ff[0].price, ask_price: best_ff[1].price,
                           trade_quantity: trade_q, last: 1'b0};
            if (out_free) begin
               mem_we    = 1'b1;
               mem_waddr = best_idx_ff[0];
               mem_wdata = best_ff[0];
               mem_wdata.remaining = bid_left;
               if (bid_left == '0) begin
                  valid_in[best_idx_ff[0]] = 1'b0;
               end
               q_in     = trade_q;
               state_in = lobm_pkg::ENG_TRADE_ASK;
            end
         end
         lobm_pkg::ENG_TRADE_ASK: begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_ff[1];
            mem_wdata = best_ff[1];
            mem_wdata.remaining = ask_left;
            if (ask_left == '0) begin
               valid_in[best_idx_ff[1]] = 1'b0;
            end
            scan_start = 1'b1;
            state_in   = lobm_pkg::ENG_SCAN;
         end
         lobm_pkg::ENG_STATUS: begin
            emit_valid = 1'b1;
            if (out_free) begin
               state_in = lobm_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = lobm_pkg::ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         counter_ff <= '0;
         match_ff   <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         counter_ff <= counter_in;
         match_ff   <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      status_ff  <= status_in;
      new_idx_ff <= new_idx_in;
      q_ff       <= q_in;
   end

endmodule

// ----- design/limit_order_book_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// price-time priority limit order book with a bounded set of resting orders
// ----------------------------------------------------------------------------
// channel  direction  ports     payload
// req      in         req_*     tuser op, tdata id/side/type/price/quantity
// rsp      out        rsp_*     tuser kind, tdata status/ids/prices/qty, tlast
//
// each pass over the book reads one slot a cycle from the slot memory
// add with k fills: k + 2 passes; modify adds one pass
// cancel, end of day and a rejected add: one pass
// reset is synchronous; the book empties at once
// a stalled rsp holds the sequencer; requests queue two deep in front
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "limit_order_book_matcher_unit_assert.svh"

module limit_order_book_matcher_unit #(
   parameter int ORDER_SLOTS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [79:0]   req_tdata,   // order_id, side, order_type, price, quantity
   input  logic [1:0]    req_tuser,   // op
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,   // status, bid_id, ask_id, bid_price, ask_price,
                                      // trade_quantity
   output logic [0:0]    rsp_tuser,   // kind
   output logic          rsp_tlast
);

   logic               cmd_valid, cmd_pop;
   lobm_pkg::cmd_type  cmd;
   logic               emit_valid, out_free;
   lobm_pkg::rsp_type  emit_item;
   logic               rsp_valid_ff;
   lobm_pkg::rsp_type  rsp_ff;

   lobm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   lobm_engine #(.ORDER_SLOTS(ORDER_SLOTS)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit_item  (emit_item)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit_valid) begin
         rsp_ff <= emit_item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {5'b0, rsp_ff.trade_quantity, rsp_ff.ask_price, rsp_ff.bid_price,
                        rsp_ff.ask_id, rsp_ff.bid_id, rsp_ff.status};

   `LOBM_ASSERT(a_trade_qty_nonzero, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[130:107] != 24'd0)
   `LOBM_ASSERT(a_trade_crosses, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[86:67] >= rsp_tdata[106:87])
   `LOBM_ASSERT(a_last_is_status, clock, reset, rsp_tvalid |-> rsp_tlast == rsp_tuser[0])
   `LOBM_ASSERT_NORST(a_reset_quiet, clock, reset |=> !rsp_tvalid)

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench for limit_order_book_matcher_unit
// drives add, cancel, modify and end of day requests, predicts the trades and
// final status of each request in a local book model and compares them
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int SLOTS = 32;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int EXPECT_DEPTH = 4096;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [79:0]   req_tdata;   // order_id, side, order_type, price, quantity
   logic [1:0]    req_tuser;   // op
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [135:0]  rsp_tdata;   // status, bid_id, ask_id, bid_price, ask_price,
                               // trade_quantity
   logic [0:0]    rsp_tuser;   // kind
   logic          rsp_tlast;

   typedef struct {
      logic          kind;
      logic [2:0]    status;
      logic [31:0]   bid_id;
      logic [31:0]   ask_id;
      logic [19:0]   bid_price;
      logic [19:0]   ask_price;
      logic [23:0]   fill_qty;
      logic          last;
   } book_result_type;

   book_result_type expect_mem[EXPECT_DEPTH];
   int              expect_wr = 0;
   int              expect_rd = 0;

   bit            book_live[SLOTS];
   logic [31:0]   book_id[SLOTS];
   logic          book_side[SLOTS];
   logic [19:0]   book_price[SLOTS];
   logic [23:0]   book_left[SLOTS];
   bit            book_day[SLOTS];
   logic [31:0]   book_arrival[SLOTS];
   logic [31:0]   arrival_count;

   int  error_count = 0;
   int  idle_cycles;
   int  ready_hold;
   bit  calm;
   bit  done;

   limit_order_book_matcher_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // book model

   function automatic void expect_store(book_result_type r);
      expect_mem[expect_wr % EXPECT_DEPTH] = r;
      expect_wr++;
   endfunction

   function automatic int find_order(logic [31:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (book_live[i] && book_id[i] == id) return i;
      return -1;
   endfunction

   function automatic int best_order(logic sd);
      int b;
      b = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (!book_live[i] || book_side[i] != sd) continue;
         if (b < 0) b = i;
         else if (book_price[i] != book_price[b]) begin
            if (sd == lobm_pkg::SIDE_BUY ? book_price[i] > book_price[b]
                                         : book_price[i] < book_price[b]) b = i;
         end else if (32'(arrival_count - book_arrival[i]) >
                      32'(arrival_count - book_arrival[b])) b = i;
      end
      return b;
   endfunction

   function automatic void push_status(lobm_pkg::status_type st);
      book_result_type r;
      r = '{lobm_pkg::KIND_STATUS, st, '0, '0, '0, '0, '0, 1'b1};
      expect_store(r);
   endfunction

   function automatic void run_matching();
      int b;
      int a;
      logic [23:0] q;
      book_result_type r;
      forever begin
         b = best_order(lobm_pkg::SIDE_BUY);
         a = best_order(lobm_pkg::SIDE_SELL);
         if (b < 0 || a < 0 || book_price[b] < book_price[a]) break;
         q = book_left[b] < book_left[a] ? book_left[b] : book_left[a];
         book_left[b] -= q;
         book_left[a] -= q;
         r = '{lobm_pkg::KIND_TRADE, lobm_pkg::ST_OK, book_id[b], book_id[a],
               book_price[b], book_price[a], q, 1'b0};
         expect_store(r);
         if (book_left[b] == 0) book_live[b] = 0;
         if (book_left[a] == 0) book_live[a] = 0;
      end
   endfunction

   function automatic void predict_add(logic [31:0] id, logic sd, logic [2:0] ot,
                                       logic [19:0] px, logic [23:0] qty);
      logic opp;
      int o;
      int s;
      bit any;
      longint sum;
      opp = ~sd;
      if (find_order(id) >= 0) begin
         push_status(lobm_pkg::ST_DUPLICATE);
         return;
      end
      if (qty == 0) begin
         push_status(lobm_pkg::ST_CANNOT_FILL);
         return;
      end
      if (ot == lobm_pkg::OT_FAK) begin
         o = best_order(opp);
         if (o < 0 || (sd == lobm_pkg::SIDE_BUY ? px < book_price[o]
                                               : px > book_price[o])) begin
            push_status(lobm_pkg::ST_NO_CROSS);
            return;
         end
      end
      if (ot == lobm_pkg::OT_MARKET) begin
         any = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (!book_live[i] || book_side[i] != opp) continue;
            if (!any || (opp == lobm_pkg::SIDE_BUY ? book_price[i] < px
                                                   : book_price[i] > px))
               px = book_price[i];
            any = 1;
         end
         if (!any) begin
            push_status(lobm_pkg::ST_EMPTY_SIDE);
            return;
         end
         ot = lobm_pkg::OT_GTC;
      end
      if (ot == lobm_pkg::OT_FOK) begin
         sum = 0;
         for (int i = 0; i < SLOTS; i++)
            if (book_live[i] && book_side[i] == opp &&
                (sd == lobm_pkg::SIDE_BUY ? book_price[i] <= px : book_price[i] >= px))
               sum += book_left[i];
         if (sum < qty) begin
            push_status(lobm_pkg::ST_CANNOT_FILL);
            return;
         end
      end
      s = -1;
      for (int i = 0; i < SLOTS; i++)
         if (!book_live[i]) begin
            s = i;
            break;
         end
      if (s < 0) begin
         push_status(lobm_pkg::ST_BOOK_FULL);
         return;
      end
      book_live[s] = 1;
      book_id[s] = id;
      book_side[s] = sd;
      book_price[s] = px;
      book_left[s] = qty;
      book_day[s] = (ot == lobm_pkg::OT_GFD);
      book_arrival[s] = arrival_count;
      arrival_count++;
      run_matching();
      if (ot == lobm_pkg::OT_FAK && book_live[s]) begin
         book_live[s] = 0;
         push_status(lobm_pkg::ST_CANCELLED);
      end else push_status(lobm_pkg::ST_OK);
   endfunction

   function automatic void predict_request(lobm_pkg::op_type op, logic [31:0] id,
                                           logic sd, logic [2:0] ot, logic [19:0] px,
                                           logic [23:0] qty);
      int s;
      if (ot > 3'd4) ot = lobm_pkg::OT_GTC;
      case (op)
         lobm_pkg::OP_ADD: predict_add(id, sd, ot, px, qty);
         lobm_pkg::OP_CANCEL: begin
            s = find_order(id);
            if (s < 0) push_status(lobm_pkg::ST_UNKNOWN_ID);
            else begin
               book_live[s] = 0;
               push_status(lobm_pkg::ST_OK);
            end
         end
         lobm_pkg::OP_MODIFY: begin
            s = find_order(id);
            if (s < 0) push_status(lobm_pkg::ST_UNKNOWN_ID);
            else begin
               ot = book_day[s] ? lobm_pkg::OT_GFD : lobm_pkg::OT_GTC;
               book_live[s] = 0;
               predict_add(id, sd, ot, px, qty);
            end
         end
         default: begin
            for (int i = 0; i < SLOTS; i++)
               if (book_live[i] && book_day[i]) book_live[i] = 0;
            push_status(lobm_pkg::ST_OK);
         end
      endcase
   endfunction

   // sender

   task automatic send_request(lobm_pkg::op_type op, logic [31:0] id, logic sd,
                               logic [2:0] ot, logic [19:0] px, logic [23:0] qty);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {qty, px, ot, sd, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(op, id, sd, ot, px, qty);
   endtask

   task automatic send_add(logic [31:0] id, logic sd, logic [2:0] ot, logic [19:0] px,
                           logic [23:0] qty);
      send_request(lobm_pkg::OP_ADD, id, sd, ot, px, qty);
   endtask

   function automatic logic [31:0] live_or_new_id();
      int s;
      s = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 3) != 0 && book_live[s]) return book_id[s];
      return $urandom_range(1, 60);
   endfunction

   // checker

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (calm) rsp_tready <= 1'b1;
      else if (ready_hold > 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= $urandom_range(0, 11);
      end else rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      book_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expect_wr == expect_rd) begin
            $error("unexpected transaction kind %0d", rsp_tuser);
            error_count++;
         end else begin
            e = expect_mem[expect_rd % EXPECT_DEPTH];
            expect_rd++;
            if (rsp_tuser[0] !== e.kind) begin
               $error("kind expected %0h actual %0h", e.kind, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tdata[2:0] !== e.status) begin
               $error("status expected %0h actual %0h", e.status, rsp_tdata[2:0]);
               error_count++;
            end
            if (rsp_tdata[34:3] !== e.bid_id) begin
               $error("bid_id expected %0h actual %0h", e.bid_id, rsp_tdata[34:3]);
               error_count++;
            end
            if (rsp_tdata[66:35] !== e.ask_id) begin
               $error("ask_id expected %0h actual %0h", e.ask_id, rsp_tdata[66:35]);
               error_count++;
            end
            if (rsp_tdata[86:67] !== e.bid_price) begin
               $error("bid_price expected %0h actual %0h", e.bid_price, rsp_tdata[86:67]);
               error_count++;
            end
            if (rsp_tdata[106:87] !== e.ask_price) begin
               $error("ask_price expected %0h actual %0h", e.ask_price,
                      rsp_tdata[106:87]);
               error_count++;
            end
            if (rsp_tdata[130:107] !== e.fill_qty) begin
               $error("trade_quantity expected %0h actual %0h", e.fill_qty,
                      rsp_tdata[130:107]);
               error_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last expected %0h actual %0h", e.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!done && idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // tests

   task automatic test_rejects();
      send_request(lobm_pkg::OP_CANCEL, 32'd7, lobm_pkg::SIDE_BUY, lobm_pkg::OT_GTC,
                   20'd0, 24'd1);
      send_request(lobm_pkg::OP_MODIFY, 32'd7, lobm_pkg::SIDE_BUY, lobm_pkg::OT_GTC,
                   20'd0, 24'd1);
      send_add(32'd1, lobm_pkg::SIDE_BUY, lobm_pkg::OT_MARKET, 20'd0, 24'd5);
      send_add(32'd2, lobm_pkg::SIDE_SELL, lobm_pkg::OT_FAK, 20'hFFFFF, 24'd5);
      send_add(32'd3, lobm_pkg::SIDE_BUY, lobm_pkg::OT_FOK, 20'hFFFFF, 24'd5);
      send_add(32'd4, lobm_pkg::SIDE_BUY, lobm_pkg::OT_GTC, 20'h00000, 24'hFFFFFF);
      send_add(32'd4, lobm_pkg::SIDE_SELL, lobm_pkg::OT_GTC, 20'h00010, 24'd3);
      send_add(32'hFFFFFFFF, lobm_pkg::SIDE_SELL, lobm_pkg::OT_GFD, 20'hFFFFF, 24'd1);
   endtask

   task automatic test_matching();
      send_add(32'd10, lobm_pkg::SIDE_SELL, lobm_pkg::OT_GTC, 20'd100, 24'd10);
      send_add(32'd11, lobm_pkg::SIDE_SELL, lobm_pkg::OT_GTC, 20'd100, 24'd10);
      send_add(32'd12, lobm_pkg::SIDE_SELL, lobm_pkg::OT_GFD, 20'd90, 24'd4);
      send_add(32'd13, lobm_pkg::SIDE_BUY, lobm_pkg::OT_FOK, 20'd100, 24'd15);
      send_add(32'd14, lobm_pkg::SIDE_BUY, lobm_pkg::OT_FOK, 20'd100, 24'd100);
      send_add(32'd15, lobm_pkg::SIDE_BUY, lobm_pkg::OT_FAK, 20'd100, 24'd50);
      send_add(32'd16, lobm_pkg::SIDE_BUY, lobm_pkg::OT_MARKET, 20'd5, 24'd3);
      send_add(32'd17, lobm_pkg::SIDE_SELL, lobm_pkg::OT_MARKET, 20'd5, 24'hFFFFFF);
      send_add(32'd18, lobm_pkg::SIDE_BUY, 3'd7, 20'd50, 24'd8);
      send_request(lobm_pkg::OP_MODIFY, 32'd18, lobm_pkg::SIDE_SELL, lobm_pkg::OT_FAK,
                   20'd40, 24'd2);
      send_request(lobm_pkg::OP_MODIFY, 32'hFFFFFFFF, lobm_pkg::SIDE_SELL,
                   lobm_pkg::OT_GTC, 20'd0, 24'd2);
      send_request(lobm_pkg::OP_END_DAY, 32'd0, lobm_pkg::SIDE_BUY, lobm_pkg::OT_GTC,
                   20'd0, 24'd0);
      send_request(lobm_pkg::OP_CANCEL, 32'd18, lobm_pkg::SIDE_BUY, lobm_pkg::OT_GTC,
                   20'd0, 24'd0);
   endtask

   task automatic test_full_book();
      for (int i = 0; i < SLOTS + 1; i++)
         send_add(32'd200 + i, lobm_pkg::SIDE_BUY,
                  i[0] ? lobm_pkg::OT_GFD : lobm_pkg::OT_GTC, 20'(10 + i), 24'(1 + i));
      send_add(32'd300, lobm_pkg::SIDE_SELL, lobm_pkg::OT_GTC, 20'd0, 24'd600);
      send_request(lobm_pkg::OP_END_DAY, 32'hA5A5A5A5, lobm_pkg::SIDE_SELL,
                   lobm_pkg::OT_MARKET, 20'hFFFFF, 24'hFFFFFF);
   endtask

   task automatic test_random(int count);
      lobm_pkg::op_type op;
      logic [2:0] ot;
      logic [19:0] px;
      logic [23:0] qty;
      int pick;
      for (int n = 0; n < count; n++) begin
         if (n > count - 40) calm = 1;
         pick = $urandom_range(0, 99);
         if (pick < 62) op = lobm_pkg::OP_ADD;
         else if (pick < 78) op = lobm_pkg::OP_CANCEL;
         else if (pick < 94) op = lobm_pkg::OP_MODIFY;
         else op = lobm_pkg::OP_END_DAY;
         ot = (pick % 11 == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         if ($urandom_range(0, 19) == 0) begin
            px = 20'($urandom);
            qty = 24'($urandom);
         end else begin
            px = 20'(1000 + $urandom_range(0, 12));
            qty = 24'($urandom_range(1, 20));
         end
         if ($urandom_range(0, 39) == 0) qty = '0;
         send_request(op, op == lobm_pkg::OP_ADD && $urandom_range(0, 1)
                      ? 32'($urandom_range(1, 60))
                      : ($urandom_range(0, 19) == 0 ? 32'($urandom) : live_or_new_id()),
                      1'($urandom_range(0, 1)), ot, px, qty);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      calm = 0;
      done = 0;
      arrival_count = 0;
      for (int i = 0; i < SLOTS; i++) book_live[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_rejects();
      test_matching();
      test_full_book();
      test_random(230);
      req_tvalid <= 1'b0;
      while (expect_wr != expect_rd) @(posedge clock);
      done = 1;
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
